[src/skf_pkg.sv]
`default_nettype none

package skf_pkg;

    // Word format: signed/unsigned Q16.16 in 32-bit words
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    // Serial multiply/divide unit widths
    localparam int OPB_W  = DATA_W + 1;          // magnitude of a 33-bit difference
    localparam int PROD_W = DATA_W + OPB_W + 1;  // product plus rounding headroom
    localparam int STEPS  = OPB_W;               // bits per multiply and per divide pass
    localparam int CNT_W  = $clog2(STEPS);

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_MEAS_VAR   = 2'd0;
    localparam logic [IDX_W-1:0] REG_MOTION_VAR = 2'd1;
    localparam logic [IDX_W-1:0] REG_INIT_MEAN  = 2'd2;
    localparam logic [IDX_W-1:0] REG_INIT_VAR   = 2'd3;

    localparam logic [DATA_W-1:0] RST_MEAS_VAR   = DATA_W'(64'd4   << FRAC_W);
    localparam logic [DATA_W-1:0] RST_MOTION_VAR = DATA_W'(64'd2   << FRAC_W);
    localparam logic [DATA_W-1:0] RST_INIT_MEAN  = DATA_W'(64'd5   << FRAC_W);
    localparam logic [DATA_W-1:0] RST_INIT_VAR   = DATA_W'(64'd500 << FRAC_W);

endpackage

`default_nettype wire

[src/skf_muldiv.sv]
`default_nettype none

// Rounded a*b/d: shift-add multiply one bit per cycle, one rounding add,
// then restoring division one quotient bit per cycle. d must be nonzero.
module skf_muldiv
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [skf_pkg::DATA_W-1:0]  a,
    input  wire logic [skf_pkg::OPB_W-1:0]   b,
    input  wire logic [skf_pkg::OPB_W-1:0]   d,
    output logic                             done,
    output logic [skf_pkg::OPB_W-1:0]        q
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_RND  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    localparam int OB = skf_pkg::OPB_W;
    localparam int PW = skf_pkg::PROD_W;

    logic [1:0]                     state_reg, state_next;
    logic [skf_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [PW-1:0]                  acc_reg, acc_next;
    logic [skf_pkg::DATA_W-1:0]     a_reg;
    logic [OB-1:0]                  d_reg;

    logic [OB:0]                    mul_sum;
    logic [OB:0]                    trial;
    logic [OB:0]                    trial_sub;
    logic                           ge;
    logic [OB-1:0]                  rem_new;

    always_comb
    begin
        // high half holds the running partial product, low half the multiplier bits
        mul_sum   = {1'b0, acc_reg[PW-1:OB]}
                  + (acc_reg[0] ? (OB+1)'(a_reg) : (OB+1)'(0));
        trial     = {acc_reg[PW-1:OB], acc_reg[OB-1]};
        trial_sub = trial - {1'b0, d_reg};
        ge        = (trial >= {1'b0, d_reg});
        rem_new   = ge ? trial_sub[OB-1:0] : trial[OB-1:0];

        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    acc_next   = {(PW-OB)'(0), b};
                    cnt_next   = skf_pkg::CNT_W'(skf_pkg::STEPS - 1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_next = {mul_sum, acc_reg[OB-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_RND;
            end
            ST_RND:
            begin
                acc_next   = acc_reg + PW'(d_reg >> 1);
                cnt_next   = skf_pkg::CNT_W'(skf_pkg::STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // quotient bits enter at the bottom as numerator bits leave
                acc_next = {rem_new, acc_reg[OB-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (state_reg == ST_IDLE && start)
        begin
            a_reg <= a;
            d_reg <= d;
        end
    end

    assign done = done_reg;
    assign q    = acc_reg[OB-1:0];

endmodule

`default_nettype wire

[src/scalar_kalman_filter.sv]
`default_nettype none

// Channel   Dir  Signals                        Contents
// s_axis    in   s_tvalid/s_tready/s_tdata/tuser  measurement, motion_step; tuser = restart
// m_axis    out  m_tvalid/m_tready/m_tdata/tuser  updated/predicted mean and variance;
//                                                 tuser = saturated
// apb       in   psel/penable/pwrite/paddr/...    4 registers at byte offsets 0,4,8,12
//
// Each transaction, acceptance to acceptance: accept, operand setup, multiply steps,
// rounding add, divide steps, done handoff, POST1, POST2 (a zero v+mv skips the units);
// the two serial multiply/divide units run side by side. s_tready is high only in idle.
// A finished result waits in the output register while the next item is accepted;
// that item stalls at its final step only while the register is still full.
// Reset loads the default registers and sets the estimate to init_mean/init_variance.
module scalar_kalman_filter
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [2*skf_pkg::DATA_W-1:0]     s_tdata,   // measurement, motion_step
    input  wire logic                             s_tuser,   // restart

    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [4*skf_pkg::DATA_W-1:0]          m_tdata,   // updated_mean, updated_variance,
                                                             // predicted_mean, predicted_variance
    output logic                                  m_tuser,   // saturated

    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [skf_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int DW = skf_pkg::DATA_W;
    localparam int OB = skf_pkg::OPB_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_POST1 = 3'd3;
    localparam logic [2:0] ST_POST2 = 3'd4;

    logic [2:0]              state_reg, state_next;

    logic [DW-1:0]           meas_var_reg, motion_var_reg, init_mean_reg, init_var_reg;
    logic [DW-1:0]           est_mean_reg, est_var_reg;
    logic [DW-1:0]           z_reg, step_reg;
    logic                    neg_reg, zero_den_reg;
    logic [DW-1:0]           um_reg, uv_reg;

    logic                    out_valid_reg;
    logic [4*DW-1:0]         out_data_reg;
    logic                    out_sat_reg;

    logic                    wr_en;
    logic [skf_pkg::IDX_W-1:0] wr_idx;

    logic                    accept;
    logic                    out_free;
    logic                    start;
    logic                    done0, done1;
    logic [OB-1:0]           q0, q1;

    logic [OB-1:0]           diff;
    logic [OB-1:0]           mag;
    logic [OB-1:0]           denom;
    logic [OB-1:0]           um_wide;
    logic [OB-1:0]           pm_wide;
    logic [OB-1:0]           pv_wide;
    logic                    pm_ovf;
    logic [DW-1:0]           pm_val, pv_val;

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[skf_pkg::IDX_W+1:2];

    always_comb
    begin
        case (wr_idx)
            skf_pkg::REG_MEAS_VAR:   prdata = meas_var_reg;
            skf_pkg::REG_MOTION_VAR: prdata = motion_var_reg;
            skf_pkg::REG_INIT_MEAN:  prdata = init_mean_reg;
            skf_pkg::REG_INIT_VAR:   prdata = init_var_reg;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_var_reg   <= skf_pkg::RST_MEAS_VAR;
            motion_var_reg <= skf_pkg::RST_MOTION_VAR;
            init_mean_reg  <= skf_pkg::RST_INIT_MEAN;
            init_var_reg   <= skf_pkg::RST_INIT_VAR;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                skf_pkg::REG_MEAS_VAR:   meas_var_reg   <= pwdata[DW-1:0];
                skf_pkg::REG_MOTION_VAR: motion_var_reg <= pwdata[DW-1:0];
                skf_pkg::REG_INIT_MEAN:  init_mean_reg  <= pwdata[DW-1:0];
                skf_pkg::REG_INIT_VAR:   init_var_reg   <= pwdata[DW-1:0];
                default:                 ;
            endcase
        end
    end

    // datapath
    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        diff    = {z_reg[DW-1], z_reg} - {est_mean_reg[DW-1], est_mean_reg};
        mag     = diff[OB-1] ? (OB'(0) - diff) : diff;
        denom   = {1'b0, est_var_reg} + {1'b0, meas_var_reg};
        start   = (state_reg == ST_PREP) && (denom != '0);

        // the updated mean lies between m and z, so 33 bits never overflow here
        um_wide = neg_reg ? ({est_mean_reg[DW-1], est_mean_reg} - q0)
                          : ({est_mean_reg[DW-1], est_mean_reg} + q0);

        pm_wide = {um_reg[DW-1], um_reg} + {step_reg[DW-1], step_reg};
        pm_ovf  = (pm_wide[OB-1] != pm_wide[OB-2]);
        if (pm_ovf)
            pm_val = pm_wide[OB-1] ? {1'b1, (DW-1)'(0)} : {1'b0, {(DW-1){1'b1}}};
        else
            pm_val = pm_wide[DW-1:0];
        pv_wide = {1'b0, uv_reg} + {1'b0, motion_var_reg};
        pv_val  = pv_wide[OB-1] ? {DW{1'b1}} : pv_wide[DW-1:0];

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = (denom == '0) ? ST_POST1 : ST_RUN;
            end
            ST_RUN:
            begin
                // both units share a start and a fixed latency
                if (done0 && done1)
                    state_next = ST_POST1;
            end
            ST_POST1:
            begin
                state_next = ST_POST2;
            end
            ST_POST2:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            est_mean_reg  <= skf_pkg::RST_INIT_MEAN;
            est_var_reg   <= skf_pkg::RST_INIT_VAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && s_tuser)
            begin
                est_mean_reg <= init_mean_reg;
                est_var_reg  <= init_var_reg;
            end
            else if (state_reg == ST_POST2 && out_free)
            begin
                est_mean_reg <= pm_val;
                est_var_reg  <= pv_val;
            end

            if (state_reg == ST_POST2 && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            z_reg    <= s_tdata[DW-1:0];
            step_reg <= s_tdata[2*DW-1:DW];
        end
        if (state_reg == ST_PREP)
        begin
            neg_reg      <= diff[OB-1];
            zero_den_reg <= (denom == '0);
        end
        if (state_reg == ST_POST1)
        begin
            um_reg <= zero_den_reg ? est_mean_reg : um_wide[DW-1:0];
            uv_reg <= zero_den_reg ? '0 : q1[DW-1:0];
        end
        if (state_reg == ST_POST2 && out_free)
        begin
            out_data_reg <= {pv_val, pm_val, uv_reg, um_reg};
            out_sat_reg  <= pm_ovf || pv_wide[OB-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

    // gain term v*|z-m|/(v+mv)
    skf_muldiv u_mean_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .a     (est_var_reg),
        .b     (mag),
        .d     (denom),
        .done  (done0),
        .q     (q0)
    );

    // updated variance v*mv/(v+mv)
    skf_muldiv u_var_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .a     (est_var_reg),
        .b     ({1'b0, meas_var_reg}),
        .d     (denom),
        .done  (done1),
        .q     (q1)
    );

endmodule

`default_nettype wire

[bench/skf_checker.sv]
`timescale 1ns / 1ps

module skf_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [2*skf_pkg::DATA_W-1:0]    s_tdata,    // measurement, motion_step
    input  wire logic                            s_tuser,    // restart

    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [4*skf_pkg::DATA_W-1:0]    m_tdata,    // updated_mean, updated_variance,
                                                             // predicted_mean, predicted_variance
    input  wire logic                            m_tuser,    // saturated

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [skf_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [31:0]                     pwdata,

    output int                                   fail_count,
    output int                                   pending
);

    localparam int DATA_W = skf_pkg::DATA_W;
    localparam int ADDR_W = skf_pkg::ADDR_W;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] pred_var;
        logic [DATA_W-1:0] pred_mean;
        logic [DATA_W-1:0] upd_var;
        logic [DATA_W-1:0] upd_mean;
    } kf_estimate_t;

    localparam longint SMAX = (64'sd1 <<< (DATA_W - 1)) - 1;
    localparam longint SMIN = -SMAX - 1;
    localparam longint unsigned UMAX = (64'd1 << DATA_W) - 1;

    logic [DATA_W-1:0] meas_var, motion_var, init_mean, init_var;
    logic [DATA_W-1:0] est_mean, est_var;
    kf_estimate_t      estimate_q[$];
    int                mismatches;

    // a*b/d rounded to nearest, ties away from zero (all operands non-negative)
    function automatic longint unsigned rounded_ratio(longint unsigned a, longint unsigned b,
                                                      longint unsigned d);
        logic [127:0] num;
        num = {64'd0, a} * {64'd0, b} + {64'd0, d >> 1};
        num = num / {64'd0, d};
        return num[63:0];
    endfunction

    task automatic fuse_and_predict(input logic restart, input logic [DATA_W-1:0] meas,
                                    input logic [DATA_W-1:0] step_in,
                                    output kf_estimate_t r);
        longint          m, z, step, diff, um, pm;
        longint unsigned v, mv, denom, mag, q, uv, pv;
        logic            sat;
        if (restart)
        begin
            est_mean = init_mean;
            est_var  = init_var;
        end
        m     = $signed(est_mean);
        z     = $signed(meas);
        step  = $signed(step_in);
        v     = est_var;
        mv    = meas_var;
        denom = v + mv;
        if (denom == 0)
        begin
            um = m;
            uv = 0;
        end
        else
        begin
            diff = z - m;
            mag  = (diff < 0) ? -diff : diff;
            q    = rounded_ratio(v, mag, denom);
            um   = (diff < 0) ? m - longint'(q) : m + longint'(q);
            uv   = rounded_ratio(v, mv, denom);
        end
        sat = 1'b0;
        pm  = um + step;
        if (pm > SMAX)
        begin
            pm  = SMAX;
            sat = 1'b1;
        end
        if (pm < SMIN)
        begin
            pm  = SMIN;
            sat = 1'b1;
        end
        pv = uv + motion_var;
        if (pv > UMAX)
        begin
            pv  = UMAX;
            sat = 1'b1;
        end
        est_mean    = DATA_W'(pm);
        est_var     = DATA_W'(pv);
        r.upd_mean  = DATA_W'(um);
        r.upd_var   = DATA_W'(uv);
        r.pred_mean = DATA_W'(pm);
        r.pred_var  = DATA_W'(pv);
        r.sat       = sat;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kf_estimate_t want, got;
        if (!rst_n)
        begin
            meas_var   = skf_pkg::RST_MEAS_VAR;
            motion_var = skf_pkg::RST_MOTION_VAR;
            init_mean  = skf_pkg::RST_INIT_MEAN;
            init_var   = skf_pkg::RST_INIT_VAR;
            est_mean   = skf_pkg::RST_INIT_MEAN;
            est_var    = skf_pkg::RST_INIT_VAR;
            estimate_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    skf_pkg::REG_MEAS_VAR:   meas_var   = pwdata[DATA_W-1:0];
                    skf_pkg::REG_MOTION_VAR: motion_var = pwdata[DATA_W-1:0];
                    skf_pkg::REG_INIT_MEAN:  init_mean  = pwdata[DATA_W-1:0];
                    skf_pkg::REG_INIT_VAR:   init_var   = pwdata[DATA_W-1:0];
                    default: ;
                endcase
            end
            // results first: a result can never belong to an item taken at the same edge
            if (m_tvalid && m_tready)
            begin
                got.upd_mean  = m_tdata[DATA_W-1:0];
                got.upd_var   = m_tdata[2*DATA_W-1:DATA_W];
                got.pred_mean = m_tdata[3*DATA_W-1:2*DATA_W];
                got.pred_var  = m_tdata[4*DATA_W-1:3*DATA_W];
                got.sat       = m_tuser;
                if (estimate_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing pending: %s%h %h %h %h %b",
                                 $time, "um uv pm pv sat = ", got.upd_mean, got.upd_var,
                                 got.pred_mean, got.pred_var, got.sat);
                end
                else
                begin
                    want = estimate_q.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: estimate mismatch", $time);
                            $display("  exp um=%h uv=%h pm=%h pv=%h sat=%b", want.upd_mean,
                                     want.upd_var, want.pred_mean, want.pred_var, want.sat);
                            $display("  got um=%h uv=%h pm=%h pv=%h sat=%b", got.upd_mean,
                                     got.upd_var, got.pred_mean, got.pred_var, got.sat);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                fuse_and_predict(s_tuser, s_tdata[DATA_W-1:0], s_tdata[2*DATA_W-1:DATA_W],
                                 want);
                estimate_q.push_back(want);
            end
        end
        fail_count <= mismatches;
        pending    <= estimate_q.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int DATA_W         = skf_pkg::DATA_W;
    localparam int ADDR_W         = skf_pkg::ADDR_W;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int LONG_HOLD      = 600;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [2*DATA_W-1:0] s_tdata  = '0;     // measurement, motion_step
    logic                s_tuser  = 1'b0;   // restart
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [4*DATA_W-1:0] m_tdata;           // updated_mean, updated_variance,
                                            // predicted_mean, predicted_variance
    logic                m_tuser;           // saturated
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit tx_gaps     = 1'b1;
    bit rx_stalls   = 1'b1;
    bit hold_req    = 1'b0;

    scalar_kalman_filter u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    skf_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    function automatic logic [DATA_W-1:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // signed Q16.16: mostly within +-32.0 so the estimate tracks, else anything
    function automatic logic [DATA_W-1:0] rand_position();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return extreme_word();
        if (pick < 4)
            return $urandom;
        return DATA_W'($urandom_range(0, 32'h003F_FFFF)) - DATA_W'(32'h0020_0000);
    endfunction

    function automatic logic [DATA_W-1:0] rand_variance(bit allow_zero);
        int                pick;
        logic [DATA_W-1:0] v;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            v = '0;
        else if (pick == 1)
            v = '1;
        else if (pick < 5)
            v = $urandom;
        else
            v = $urandom_range(1, 32'h00FF_FFFF);
        if (v == 0 && !allow_zero)
            v = 1;
        return v;
    endfunction

    task automatic send_item(input logic restart, input logic [DATA_W-1:0] meas,
                             input logic [DATA_W-1:0] step);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 1)) ? gap_length() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= restart;
        s_tdata  <= {step, meas};
        do @(posedge clk); while (!s_tready);
    endtask

    // stop offering and wait until every pending estimate has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [skf_pkg::IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] mv, input logic [31:0] mo,
                             input logic [31:0] im, input logic [31:0] iv);
        drain();
        write_reg(skf_pkg::REG_MEAS_VAR, mv);
        write_reg(skf_pkg::REG_MOTION_VAR, mo);
        write_reg(skf_pkg::REG_INIT_MEAN, im);
        write_reg(skf_pkg::REG_INIT_VAR, iv);
    endtask

    // receiver side
    initial
    begin
        int stall;
        bit hold_taken;
        stall      = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                stall      = LONG_HOLD;
            end
            else if (stall == 0 && rx_stalls && $urandom_range(0, 9) == 0)
                stall = gap_length();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable && pwrite))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL scalar_kalman_filter");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: estimate starts at 5.0 / 500.0
        send_item(1'b0, 32'h0000_0000, 32'h0000_0000);
        send_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);   // mean clamps high
        send_item(1'b0, 32'h8000_0000, 32'h8000_0000);   // mean clamps low
        send_item(1'b1, 32'h0001_0000, 32'hFFFF_0000);
        send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(1'b0, 32'h1234_5678, 32'h0000_0000);

        // zero measurement variance, then both variances zero
        configure(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(1'b1, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(1'b0, 32'h0005_0000, 32'h0001_0000);
        send_item(1'b0, 32'h8000_0000, 32'h8000_0000);
        send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // variance clamps at the unsigned maximum
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
        send_item(1'b1, 32'h8000_0000, 32'h0000_0000);
        send_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(1'b0, 32'h0000_0000, 32'h8000_0000);
        send_item(1'b1, 32'h8000_0000, 32'h8000_0000);

        configure(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(1'b1, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(1'b0, 32'h8000_0000, 32'h0000_0000);
        send_item(1'b0, 32'hFFFF_FFFF, 32'h0000_0001);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            configure(rand_variance(1'b0), rand_variance(1'b1), rand_position(),
                      rand_variance(1'b0));
            // phase 1 runs back to back; phase 3 keeps offering through a long output hold
            tx_gaps   = !(phase == 1 || phase == 3);
            rx_stalls = (phase != 1);
            if (phase == 3)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    drain();
                send_item($urandom_range(0, 15) == 0, rand_position(), rand_position());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS scalar_kalman_filter");
        else
            $display("FAIL scalar_kalman_filter");
        $finish;
    end

endmodule
